/* rtl/core/npc_pkg.sv */
`timescale 1ns / 1ps

package npc_pkg;

    localparam int NPC_ENTRIES = 256;

    typedef enum logic [1:0] {
        MODE_FIND  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } npc_mode_t;

    typedef struct packed {
        logic load_op;
        logic scan_step;
        logic rd_issue;
        logic load_find;
        logic load_read;
    } npc_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } npc_status_t;

    function automatic logic [4:0] npc_expand_r(input logic [2:0] v);
        logic [4:0] res;
        unique case (v)
            3'd0: res = 5'd0;
            3'd1: res = 5'd4;
            3'd2: res = 5'd8;
            3'd3: res = 5'd13;
            3'd4: res = 5'd17;
            3'd5: res = 5'd22;
            3'd6: res = 5'd26;
            default: res = 5'd31;
        endcase
        return res;
    endfunction

    function automatic logic [5:0] npc_expand_g(input logic [2:0] v);
        logic [5:0] res;
        unique case (v)
            3'd0: res = 6'd0;
            3'd1: res = 6'd9;
            3'd2: res = 6'd18;
            3'd3: res = 6'd27;
            3'd4: res = 6'd36;
            3'd5: res = 6'd45;
            3'd6: res = 6'd54;
            default: res = 6'd63;
        endcase
        return res;
    endfunction

    function automatic logic [4:0] npc_expand_b(input logic [1:0] v);
        logic [4:0] res;
        unique case (v)
            2'd0: res = 5'd0;
            2'd1: res = 5'd10;
            2'd2: res = 5'd20;
            default: res = 5'd31;
        endcase
        return res;
    endfunction

    // Power-on palette color of an entry, before the black and white ends are forced.
    function automatic logic [15:0] npc_reset_color(input logic [7:0] idx);
        return {npc_expand_r(idx[7:5]), npc_expand_g(idx[4:2]), npc_expand_b(idx[1:0])};
    endfunction

endpackage

/* rtl/core/npc_ctrl.sv */
`timescale 1ns / 1ps

module npc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  npc_pkg::npc_status_t status,
    output npc_pkg::npc_cmd_t    cmd
);
    import npc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FRES,
        ST_RD,
        ST_RRES
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_op = 1'b1;
                    if (mode == MODE_FIND)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (mode == MODE_READ)
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FRES;
                end
            end
            ST_FRES:
            begin
                if (status.out_free)
                begin
                    cmd.load_find = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RRES;
            end
            ST_RRES:
            begin
                if (status.out_free)
                begin
                    cmd.load_read = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_find || cmd.load_read) |-> status.out_free)
        else $error("result loaded while output register busy");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && status.scan_last) |=> (state_reg == ST_DRAIN))
        else $error("scan did not stop after last entry");

    a_read_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |=> (state_reg == ST_RRES))
        else $error("read did not move on to its result");

endmodule

/* rtl/core/npc_dpath.sv */
`timescale 1ns / 1ps

module npc_dpath
#(
    parameter int ENTRIES = npc_pkg::NPC_ENTRIES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  npc_pkg::npc_cmd_t    cmd,
    output npc_pkg::npc_status_t status,
    input  logic [1:0]           mode,
    input  logic [7:0]           entry_index,
    input  logic [15:0]          color,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           match_index,
    output logic [15:0]          color_out
);
    import npc_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    logic [15:0]   mem [ENTRIES];
    logic          written_reg [ENTRIES];

    logic [15:0]   op_color_reg;
    logic [AW-1:0] op_idx_reg;
    logic          op_in_range_reg;
    logic          in_range;

    logic [AW-1:0] scan_cnt_reg;
    logic [AW-1:0] rd_addr;
    logic          rd_en;

    logic [15:0]   rd_data_reg;
    logic          rd_written_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          s1_vld_reg;
    logic [15:0]   entry_val;

    logic [4:0]    dr;
    logic [5:0]    dg;
    logic [4:0]    db;
    logic [9:0]    sq_r;
    logic [11:0]   sq_g;
    logic [9:0]    sq_b;
    logic [12:0]   dist_next;
    logic [12:0]   dist_reg;
    logic [AW-1:0] s2_idx_reg;
    logic          s2_vld_reg;

    logic          best_have_reg;
    logic [12:0]   best_dist_reg;
    logic [AW-1:0] best_idx_reg;

    logic          out_valid_reg;
    logic [7:0]    match_index_reg;
    logic [15:0]   color_out_reg;

    assign in_range = ({1'b0, entry_index} < 9'(ENTRIES));
    assign rd_addr  = cmd.scan_step ? scan_cnt_reg : op_idx_reg;
    assign rd_en    = cmd.scan_step || cmd.rd_issue;

    always_ff @(posedge clk)
    begin
        if (cmd.load_op && mode == MODE_WRITE && in_range)
        begin
            mem[entry_index[AW-1:0]] <= color;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                written_reg[i] <= 1'b0;
            end
        end
        else if (cmd.load_op && mode == MODE_WRITE && in_range)
        begin
            written_reg[entry_index[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            op_color_reg    <= color;
            op_idx_reg      <= entry_index[AW-1:0];
            op_in_range_reg <= in_range;
        end
        if (rd_en)
        begin
            rd_written_reg <= written_reg[rd_addr];
            rd_addr_reg    <= rd_addr;
        end
        dist_reg   <= dist_next;
        s2_idx_reg <= rd_addr_reg;
    end

    always_comb
    begin
        if (rd_written_reg)
        begin
            entry_val = rd_data_reg;
        end
        else if (rd_addr_reg == '0)
        begin
            entry_val = 16'h0000;
        end
        else if (rd_addr_reg == AW'(ENTRIES - 1))
        begin
            entry_val = 16'hffff;
        end
        else
        begin
            entry_val = npc_reset_color(8'(rd_addr_reg));
        end
    end

    always_comb
    begin
        dr = (op_color_reg[15:11] > entry_val[15:11]) ? op_color_reg[15:11] - entry_val[15:11]
                                                      : entry_val[15:11] - op_color_reg[15:11];
        dg = (op_color_reg[10:5] > entry_val[10:5]) ? op_color_reg[10:5] - entry_val[10:5]
                                                    : entry_val[10:5] - op_color_reg[10:5];
        db = (op_color_reg[4:0] > entry_val[4:0]) ? op_color_reg[4:0] - entry_val[4:0]
                                                  : entry_val[4:0] - op_color_reg[4:0];
        sq_r      = {5'd0, dr} * {5'd0, dr};
        sq_g      = {6'd0, dg} * {6'd0, dg};
        sq_b      = {5'd0, db} * {5'd0, db};
        dist_next = 13'(sq_r) + 13'(sq_g) + 13'(sq_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg  <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            best_have_reg <= 1'b0;
            best_dist_reg <= '0;
            best_idx_reg  <= '0;
        end
        else
        begin
            s1_vld_reg <= cmd.scan_step;
            s2_vld_reg <= s1_vld_reg;
            if (cmd.load_op)
            begin
                scan_cnt_reg  <= '0;
                best_have_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (s2_vld_reg && (!best_have_reg || dist_reg < best_dist_reg))
                begin
                    best_have_reg <= 1'b1;
                    best_dist_reg <= dist_reg;
                    best_idx_reg  <= s2_idx_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_find || cmd.load_read)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_find)
        begin
            match_index_reg <= 8'(best_idx_reg);
            color_out_reg   <= 16'h0000;
        end
        else if (cmd.load_read)
        begin
            match_index_reg <= 8'h00;
            color_out_reg   <= op_in_range_reg ? entry_val : 16'h0000;
        end
    end

    assign status.scan_last = (scan_cnt_reg == AW'(ENTRIES - 1));
    assign status.pipe_busy = s1_vld_reg || s2_vld_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign match_index = match_index_reg;
    assign color_out   = color_out_reg;

    a_best_before_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_find |-> (best_have_reg && !s1_vld_reg && !s2_vld_reg))
        else $error("find result loaded before the search finished");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> $past(s1_vld_reg))
        else $error("distance stage valid without a preceding read");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=>
            (out_valid_reg && $stable(match_index_reg) && $stable(color_out_reg)))
        else $error("stalled result changed");

endmodule

/* rtl/core/nearest_palette_color_core.sv */
`timescale 1ns / 1ps

// Nearest palette color core. Holds an ENTRIES-deep RGB565 palette that powers up with
// RGB332 colors expanded to RGB565, black at entry 0 and white at the last entry. A find
// transaction (mode 0) returns in match_index the entry with the least squared 5/6/5-bit
// channel distance, lowest index on a tie. A write transaction (mode 1) stores color and
// gives no result; a read transaction (mode 2) returns the stored color in color_out, or
// zero beyond the palette. Transactions are handled one at a time. The search of a find walks
// the palette memory's single read port one entry per cycle. A read issues its palette access
// before its result is loaded, and a write is done when it is accepted. The result sits in an
// output register, so a new transaction can be accepted while it waits to be taken.
module nearest_palette_color_core
#(
    parameter int ENTRIES = npc_pkg::NPC_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  entry_index,
    input  logic [15:0] color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  match_index,
    output logic [15:0] color_out
);
    import npc_pkg::*;

    npc_cmd_t    cmd;
    npc_status_t status;

    npc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd)
    );

    npc_dpath
    #(
        .ENTRIES (ENTRIES)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (mode),
        .entry_index (entry_index),
        .color       (color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .match_index (match_index),
        .color_out   (color_out)
    );

endmodule

/* verif/palette_match_sb_pkg.sv */
`timescale 1ns / 1ps

package palette_match_sb_pkg;

    import npc_pkg::*;

    typedef struct {
        logic [7:0]  match_index;
        logic [15:0] color_out;
    } palette_result_t;

    class palette_scoreboard;

        logic [15:0]     palette [NPC_ENTRIES];
        palette_result_t expected_results [$];
        int unsigned     mismatches;

        function new();
            int unsigned r;
            int unsigned g;
            int unsigned b;
            mismatches = 0;
            for (int unsigned i = 0; i < NPC_ENTRIES; i++)
            begin
                r = (i >> 5) & 7;
                g = (i >> 2) & 7;
                b = i & 3;
                palette[i] = 16'(((r * 31 / 7) << 11) | ((g * 63 / 7) << 5) | (b * 31 / 3));
            end
            palette[0] = 16'h0000;
            palette[NPC_ENTRIES - 1] = 16'hffff;
        endfunction

        function int unsigned channel_sq(int a, int b);
            return (a - b) * (a - b);
        endfunction

        function logic [7:0] nearest_entry(logic [15:0] c);
            int unsigned best_dist;
            int unsigned sq_dist;
            logic [7:0]  best_idx;
            logic [15:0] p;
            best_dist = 32'hffff_ffff;
            best_idx = '0;
            for (int i = 0; i < NPC_ENTRIES; i++)
            begin
                p = palette[i];
                sq_dist = channel_sq(int'(c[15:11]), int'(p[15:11]))
                        + channel_sq(int'(c[10:5]), int'(p[10:5]))
                        + channel_sq(int'(c[4:0]), int'(p[4:0]));
                if (sq_dist < best_dist)
                begin
                    best_dist = sq_dist;
                    best_idx = 8'(i);
                    if (sq_dist == 0)
                        break;
                end
            end
            return best_idx;
        endfunction

        function void note_transaction(logic [1:0] mode, logic [7:0] idx, logic [15:0] c);
            palette_result_t res;
            case (mode)
                MODE_FIND:
                begin
                    res.match_index = nearest_entry(c);
                    res.color_out = '0;
                    expected_results.push_back(res);
                end
                MODE_WRITE:
                begin
                    if (int'(idx) < NPC_ENTRIES)
                        palette[idx] = c;
                end
                MODE_READ:
                begin
                    res.match_index = '0;
                    res.color_out = (int'(idx) < NPC_ENTRIES) ? palette[idx] : '0;
                    expected_results.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [7:0] match_index, logic [15:0] color_out);
            palette_result_t exp_res;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: match_index %0d color_out 0x%04h",
                       match_index, color_out);
                mismatches++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (match_index !== exp_res.match_index)
            begin
                $error("match_index: expected %0d, actual %0d",
                       exp_res.match_index, match_index);
                mismatches++;
            end
            if (color_out !== exp_res.color_out)
            begin
                $error("color_out: expected 0x%04h, actual 0x%04h",
                       exp_res.color_out, color_out);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

    endclass

endpackage

/* verif/tb_nearest_palette_color_core.sv */
`timescale 1ns / 1ps

module tb_nearest_palette_color_core;

    import npc_pkg::*;
    import palette_match_sb_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1950;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_FIND;
    logic [7:0]  entry_index = '0;
    logic [15:0] color = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  match_index;
    logic [15:0] color_out;

    bit                calm = 1'b0;
    int unsigned       random_sent = 0;
    palette_scoreboard sb;

    nearest_palette_color_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .entry_index (entry_index),
        .color       (color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .match_index (match_index),
        .color_out   (color_out)
    );

    initial
    begin
        forever
            #1 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[nearest_palette_color_core] ERROR");
        $finish;
    end

    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 16);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(match_index, color_out);
    end

    task automatic send_item(logic [1:0] m, logic [7:0] idx, logic [15:0] c);
        while (!calm && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        entry_index <= idx;
        color <= c;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_transaction(m, idx, c);
        if (m != MODE_UNUSED)
            random_sent++;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_color();
        logic [15:0] c;
        case ($urandom_range(4))
            0: c = 16'($urandom());
            1: c = sb.palette[$urandom_range(NPC_ENTRIES - 1)];
            2: c = sb.palette[$urandom_range(NPC_ENTRIES - 1)] ^ 16'($urandom_range(15));
            3: c = sb.palette[$urandom_range(NPC_ENTRIES - 1)] ^ (16'h1 << $urandom_range(15));
            default: c = $urandom_range(1) ? 16'hffff : 16'h0000;
        endcase
        return c;
    endfunction

    task automatic write_find_read();
        logic [7:0]  idx;
        logic [15:0] c;
        idx = 8'($urandom_range(NPC_ENTRIES - 1));
        c = pick_color();
        send_item(MODE_WRITE, idx, c);
        send_item(MODE_FIND, 8'($urandom()), $urandom_range(1) ? c : c ^ 16'($urandom_range(3)));
        send_item(MODE_READ, idx, 16'($urandom()));
    endtask

    initial
    begin
        logic [1:0] m;
        sb = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(MODE_FIND, 8'hff, 16'h0000);
        send_item(MODE_FIND, 8'h00, 16'hffff);
        send_item(MODE_READ, 8'd0, 16'h0000);
        send_item(MODE_READ, 8'd255, 16'hffff);
        send_item(MODE_READ, 8'd128, 16'h0000);
        send_item(MODE_FIND, 8'd0, sb.palette[77]);
        send_item(MODE_FIND, 8'd0, 16'h0001);
        send_item(MODE_FIND, 8'd0, 16'h8000);
        send_item(MODE_FIND, 8'd0, 16'h07e0);
        send_item(MODE_FIND, 8'd0, 16'hf800);
        send_item(MODE_UNUSED, 8'hff, 16'hffff);
        send_item(MODE_READ, 8'd255, 16'h0000);
        send_item(MODE_WRITE, 8'd0, 16'hffff);
        send_item(MODE_WRITE, 8'd255, 16'h0000);
        send_item(MODE_FIND, 8'd0, 16'hffff);
        send_item(MODE_FIND, 8'd0, 16'h0000);
        send_item(MODE_WRITE, 8'd10, 16'h1234);
        send_item(MODE_WRITE, 8'd200, 16'h1234);
        send_item(MODE_FIND, 8'd0, 16'h1234);
        send_item(MODE_READ, 8'd200, 16'h0000);
        send_item(MODE_WRITE, 8'h55, 16'h5555);
        send_item(MODE_WRITE, 8'haa, 16'haaaa);
        send_item(MODE_READ, 8'h55, 16'h0000);
        send_item(MODE_READ, 8'haa, 16'h0000);
        send_item(MODE_FIND, 8'd0, 16'h5a5a);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            calm = (random_sent >= 800) && (random_sent < 1100);
            if ($urandom_range(99) < 65)
                write_find_read();
            else
            begin
                m = 2'($urandom_range(3));
                send_item(m, 8'($urandom()), $urandom_range(1) ? pick_color() : 16'($urandom()));
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (sb.mismatches == 0)
            $display("[nearest_palette_color_core] OK");
        else
            $display("[nearest_palette_color_core] ERROR");
        $finish;
    end

endmodule
